@@ src/bmp_pkg.sv @@
package bmp_pkg;

    // Table geometry: eight 16-bit breakpoints in two 64-bit words
    localparam int SLOTS          = 8;
    localparam int IDX_W          = 3;
    localparam int MV_W           = 16;
    localparam int WORD_W         = 64;
    localparam int CNT_W          = 4;
    localparam int CFG_IDX_W      = 2;

    // Datapath widths
    localparam int WID_W          = 16;
    localparam int STEP_W         = 7;
    localparam int QUO_W          = 7;
    localparam int PCT_W          = 7;
    localparam int REM_W          = WID_W + STEP_W;

    // Parameter defaults
    localparam int MAX_POINTS_DEF = 8;
    localparam int MID_DEPTH_DEF  = 2;
    localparam int OUT_DEPTH_DEF  = 16;

    localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0] PCT_ZERO    = 7'd0;
    localparam logic [CNT_W-1:0] PTS_USE_RST = 4'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PTS_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PTS_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PTS_USE = 2'd2;

    // Classification of one request
    typedef enum logic [1:0] {
        K_LOW,
        K_HIGH,
        K_SEG
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic signed [MV_W-1:0] mv;
        logic [IDX_W-1:0]       seg;   // index of the first breakpoint above mv
        logic [IDX_W-1:0]       span;  // points in use minus one
    } t_job;

    function automatic logic signed [MV_W-1:0] pt_slot(
        input logic [WORD_W-1:0] lo_w,
        input logic [WORD_W-1:0] hi_w,
        input logic [IDX_W-1:0]  idx
    );
        logic [WORD_W-1:0] word;
        begin
            word = idx[IDX_W-1] ? hi_w : lo_w;
            return word[idx[1:0]*MV_W +: MV_W];
        end
    endfunction

    // Percent per segment: 100 / span, truncated
    function automatic logic [STEP_W-1:0] step_of(input logic [IDX_W-1:0] span);
        begin
            case (span)
                3'd1:    return 7'd100;
                3'd2:    return 7'd50;
                3'd3:    return 7'd33;
                3'd4:    return 7'd25;
                3'd5:    return 7'd20;
                3'd6:    return 7'd16;
                3'd7:    return 7'd14;
                default: return 7'd0;
            endcase
        end
    endfunction

endpackage

@@ src/battery_mv_to_percent_interp.sv @@
// Battery charge estimator. Each request carries one signed millivolt
// reading and yields one charge percentage 0..100 by piecewise-linear
// interpolation over a table of up to eight ascending breakpoints (two
// 64-bit registers, four 16-bit slots each, slot 0 in the low bits) and a
// count of points in use (0 reads as 1, values above MAX_POINTS saturate).
// Below the first point the result is 0, at or above the last point 100;
// in between it is (segment-1)*step + (offset*step)/width with
// step = 100/(count-1), every division truncating. Requests enter on a
// push/full queue port and results leave on an empty/pop queue port in
// request order. One request is taken per clock while o_full is low;
// results pass the classify register, the hand-off queue, the operand
// and product stages and a seven-stage divider that resolves one quotient
// bit per stage. The user writes registers through i_cfg_we/i_cfg_idx/
// i_cfg_data only while no request is in flight; the block does not enforce it.
module battery_mv_to_percent_interp #(
    parameter int MAX_POINTS = bmp_pkg::MAX_POINTS_DEF,
    parameter int MID_DEPTH  = bmp_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH  = bmp_pkg::OUT_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [bmp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bmp_pkg::WORD_W-1:0]          i_cfg_data,
    // request side
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [bmp_pkg::MV_W-1:0]     i_battery_millivolts,
    // result side
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic [bmp_pkg::PCT_W-1:0]           o_charge_percent
);

    localparam int JW = $bits(bmp_pkg::t_job);

    logic [bmp_pkg::WORD_W-1:0] r_pts_lo;
    logic [bmp_pkg::WORD_W-1:0] r_pts_hi;
    logic [bmp_pkg::CNT_W-1:0]  r_pts_use;

    logic                       front_vld;
    bmp_pkg::t_job              front_job;
    logic                       mid_full;
    logic                       mid_empty;
    logic [JW-1:0]              mid_data;
    bmp_pkg::t_job              mid_job;
    logic                       back_take;
    logic                       back_push;
    logic [bmp_pkg::PCT_W-1:0]  back_pct;
    logic                       out_full;
    logic                       out_pop;

    // Configuration registers; writes to unused indexes drop silently
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts_lo  <= '0;
            r_pts_hi  <= '0;
            r_pts_use <= bmp_pkg::PTS_USE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bmp_pkg::CFG_PTS_LO:  r_pts_lo  <= i_cfg_data;
                bmp_pkg::CFG_PTS_HI:  r_pts_hi  <= i_cfg_data;
                bmp_pkg::CFG_PTS_USE: r_pts_use <= i_cfg_data[bmp_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: accept and classify each request against the breakpoints
    bmp_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_mv      (i_battery_millivolts),
        .i_pts_lo  (r_pts_lo),
        .i_pts_hi  (r_pts_hi),
        .i_pts_use (r_pts_use),
        .i_q_full  (mid_full),
        .o_full    (o_full),
        .o_vld     (front_vld),
        .o_job     (front_job)
    );

    // Hand-off queue: lets the front keep accepting while the back holds
    bmp_queue #(
        .WIDTH (JW),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_data  (front_job),
        .o_full  (mid_full),
        .i_pop   (back_take),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    assign mid_job = mid_data;

    // Back: interpolation datapath, issues only when the result queue has room
    bmp_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (!mid_empty),
        .i_job     (mid_job),
        .o_take    (back_take),
        .i_pts_lo  (r_pts_lo),
        .i_pts_hi  (r_pts_hi),
        .i_out_pop (out_pop),
        .o_push    (back_push),
        .o_pct     (back_pct)
    );

    assign out_pop = i_pop && !o_empty;

    // Result queue: oldest result sits on o_charge_percent while not empty
    bmp_queue #(
        .WIDTH (bmp_pkg::PCT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_pct),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_charge_percent),
        .o_empty (o_empty)
    );

    // The credit count must keep the result queue from ever overflowing
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(back_push && out_full))
        else $error("result queue pushed while full");

    // Interpolated results never exceed full charge
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_charge_percent <= bmp_pkg::PCT_FULL))
        else $error("charge percent above 100");

    // An accepted request lands in the classify register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> front_vld)
        else $error("accepted request lost at the front");

    // Back never takes from an empty hand-off queue
    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_take |-> !mid_empty)
        else $error("back took from empty hand-off queue");

endmodule

@@ src/bmp_queue.sv @@
module bmp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ src/bmp_front.sv @@
module bmp_front #(
    parameter int MAX_POINTS = bmp_pkg::MAX_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic signed [bmp_pkg::MV_W-1:0]    i_mv,
    input  logic [bmp_pkg::WORD_W-1:0]         i_pts_lo,
    input  logic [bmp_pkg::WORD_W-1:0]         i_pts_hi,
    input  logic [bmp_pkg::CNT_W-1:0]          i_pts_use,
    input  logic                               i_q_full,
    output logic                               o_full,
    output logic                               o_vld,
    output bmp_pkg::t_job                      o_job
);

    logic                          r_vld;
    bmp_pkg::t_job                 r_job, n_job;
    logic [bmp_pkg::CNT_W-1:0]     cnt;
    logic [bmp_pkg::IDX_W-1:0]     span;
    logic [bmp_pkg::IDX_W-1:0]     seg;
    logic [bmp_pkg::SLOTS-1:0]     lt;

    // Clamp the point count to 1..MAX_POINTS
    always_comb begin
        cnt = i_pts_use;
        if (cnt == '0) begin
            cnt = bmp_pkg::CNT_W'(1);
        end
        if (cnt > bmp_pkg::CNT_W'(MAX_POINTS)) begin
            cnt = bmp_pkg::CNT_W'(MAX_POINTS);
        end
        span = bmp_pkg::IDX_W'(cnt - bmp_pkg::CNT_W'(1));
    end

    // Compare against every breakpoint, pick the first one above
    always_comb begin
        for (int k = 0; k < bmp_pkg::SLOTS; k++) begin
            lt[k] = i_mv < bmp_pkg::pt_slot(i_pts_lo, i_pts_hi, bmp_pkg::IDX_W'(k));
        end
        seg = '0;
        for (int i = bmp_pkg::SLOTS - 1; i >= 1; i--) begin
            if (lt[i] && (bmp_pkg::IDX_W'(i) <= span)) begin
                seg = bmp_pkg::IDX_W'(i);
            end
        end
        n_job.mv   = i_mv;
        n_job.seg  = seg;
        n_job.span = span;
        if (lt[0]) begin
            n_job.kind = bmp_pkg::K_LOW;
        end else if (!lt[span]) begin
            n_job.kind = bmp_pkg::K_HIGH;
        end else begin
            n_job.kind = bmp_pkg::K_SEG;
        end
    end

    // Hold while the stage is loaded and the queue cannot take it
    assign o_full = r_vld && i_q_full;
    assign o_vld  = r_vld;
    assign o_job  = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_full) begin
            r_vld <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_full && i_push) begin
            r_job <= n_job;
        end
    end

endmodule

@@ src/bmp_back.sv @@
module bmp_back #(
    parameter int OUT_DEPTH = bmp_pkg::OUT_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  bmp_pkg::t_job                     i_job,
    output logic                              o_take,
    input  logic [bmp_pkg::WORD_W-1:0]        i_pts_lo,
    input  logic [bmp_pkg::WORD_W-1:0]        i_pts_hi,
    input  logic                              i_out_pop,
    output logic                              o_push,
    output logic [bmp_pkg::PCT_W-1:0]         o_pct
);

    localparam int OW = $clog2(OUT_DEPTH + 1);
    localparam int QW = bmp_pkg::QUO_W;
    localparam int BW = bmp_pkg::IDX_W + bmp_pkg::STEP_W;

    // Requests issued and not yet popped from the result queue
    logic [OW-1:0] r_outst, n_outst;

    // Operand stage
    logic                          r_s0_vld;
    logic [bmp_pkg::WID_W-1:0]     r_s0_off, n_s0_off;
    logic [bmp_pkg::WID_W-1:0]     r_s0_wid, n_s0_wid;
    logic [bmp_pkg::STEP_W-1:0]    r_s0_step, n_s0_step;
    logic [bmp_pkg::PCT_W-1:0]     r_s0_base, n_s0_base;

    // Product stage (index 0) and one quotient bit per following stage
    logic                          r_vld  [QW+1];
    logic [bmp_pkg::REM_W-1:0]     r_rem  [QW+1];
    logic [bmp_pkg::REM_W-1:0]     n_rem  [QW+1];
    logic [QW-1:0]                 r_quo  [QW+1];
    logic [QW-1:0]                 n_quo  [QW+1];
    logic [bmp_pkg::WID_W-1:0]     r_wid  [QW+1];
    logic [bmp_pkg::PCT_W-1:0]     r_base [QW+1];

    logic signed [bmp_pkg::MV_W-1:0] lo_pt;
    logic signed [bmp_pkg::MV_W-1:0] hi_pt;
    logic [bmp_pkg::MV_W:0]          d_off;
    logic [bmp_pkg::MV_W:0]          d_wid;
    logic [bmp_pkg::IDX_W-1:0]       seg_m1;
    logic [bmp_pkg::STEP_W-1:0]      step;
    logic [BW-1:0]                   base_p;
    logic [bmp_pkg::REM_W-1:0]       shd;
    logic                            ge;

    assign o_take = i_vld && ((r_outst < OW'(OUT_DEPTH)) || i_out_pop);

    always_comb begin
        n_outst = r_outst;
        if (o_take && !i_out_pop) begin
            n_outst = r_outst + OW'(1);
        end else if (i_out_pop && !o_take) begin
            n_outst = r_outst - OW'(1);
        end
    end

    // Segment end points, offset and width
    always_comb begin
        seg_m1 = bmp_pkg::IDX_W'(i_job.seg - bmp_pkg::IDX_W'(1));
        lo_pt  = bmp_pkg::pt_slot(i_pts_lo, i_pts_hi, seg_m1);
        hi_pt  = bmp_pkg::pt_slot(i_pts_lo, i_pts_hi, i_job.seg);
        d_off  = {i_job.mv[bmp_pkg::MV_W-1], i_job.mv} - {lo_pt[bmp_pkg::MV_W-1], lo_pt};
        d_wid  = {hi_pt[bmp_pkg::MV_W-1], hi_pt} - {lo_pt[bmp_pkg::MV_W-1], lo_pt};
        step   = bmp_pkg::step_of(i_job.span);
        base_p = BW'(seg_m1) * BW'(step);
        case (i_job.kind)
            bmp_pkg::K_SEG: begin
                n_s0_off  = d_off[bmp_pkg::WID_W-1:0];
                n_s0_wid  = d_wid[bmp_pkg::WID_W-1:0];
                n_s0_step = step;
                n_s0_base = base_p[bmp_pkg::PCT_W-1:0];
            end
            bmp_pkg::K_HIGH: begin
                n_s0_off  = '0;
                n_s0_wid  = bmp_pkg::WID_W'(1);
                n_s0_step = '0;
                n_s0_base = bmp_pkg::PCT_FULL;
            end
            default: begin
                n_s0_off  = '0;
                n_s0_wid  = bmp_pkg::WID_W'(1);
                n_s0_step = '0;
                n_s0_base = bmp_pkg::PCT_ZERO;
            end
        endcase
    end

    // Restoring division, one quotient bit per stage, MSB first
    always_comb begin
        n_rem[0] = bmp_pkg::REM_W'(r_s0_off) * bmp_pkg::REM_W'(r_s0_step);
        n_quo[0] = '0;
        shd      = '0;
        ge       = 1'b0;
        for (int s = 1; s <= QW; s++) begin
            shd      = bmp_pkg::REM_W'(r_wid[s-1]) << (QW - s);
            ge       = r_rem[s-1] >= shd;
            n_rem[s] = ge ? (r_rem[s-1] - shd) : r_rem[s-1];
            n_quo[s] = r_quo[s-1] | (ge ? (QW'(1) << (QW - s)) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst  <= '0;
            r_s0_vld <= 1'b0;
            for (int s = 0; s <= QW; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_outst  <= n_outst;
            r_s0_vld <= o_take;
            r_vld[0] <= r_s0_vld;
            for (int s = 1; s <= QW; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_off  <= n_s0_off;
        r_s0_wid  <= n_s0_wid;
        r_s0_step <= n_s0_step;
        r_s0_base <= n_s0_base;
        r_rem[0]  <= n_rem[0];
        r_quo[0]  <= n_quo[0];
        r_wid[0]  <= r_s0_wid;
        r_base[0] <= r_s0_base;
        for (int s = 1; s <= QW; s++) begin
            r_rem[s]  <= n_rem[s];
            r_quo[s]  <= n_quo[s];
            r_wid[s]  <= r_wid[s-1];
            r_base[s] <= r_base[s-1];
        end
    end

    assign o_push = r_vld[QW];
    assign o_pct  = bmp_pkg::PCT_W'(r_base[QW] + r_quo[QW]);

endmodule

@@ verif/tb_battery_mv_to_percent_interp.sv @@
module tb_battery_mv_to_percent_interp;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 6;
    // Settling margin after the last predicted result has been popped.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS   = 100;
    localparam int REPORT_MAX    = 10;
    localparam int MAX_BURST     = 14;

    // Index one past the register list; writes to it must be dropped.
    localparam logic [bmp_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the register file, predicts the percentage of
    // every accepted request and matches results against it in order.
    // ------------------------------------------------------------------
    class charge_ledger;
        logic [bmp_pkg::WORD_W-1:0] low_word    = '0;
        logic [bmp_pkg::WORD_W-1:0] high_word   = '0;
        logic [bmp_pkg::CNT_W-1:0]  points_used = bmp_pkg::PTS_USE_RST;
        logic [bmp_pkg::PCT_W-1:0]  pending_percent[$];
        int                         bad_count   = 0;

        function void set_register(logic [bmp_pkg::CFG_IDX_W-1:0] idx,
                                   logic [bmp_pkg::WORD_W-1:0] data);
            case (idx)
                bmp_pkg::CFG_PTS_LO:  low_word = data;
                bmp_pkg::CFG_PTS_HI:  high_word = data;
                bmp_pkg::CFG_PTS_USE: points_used = data[bmp_pkg::CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int breakpoint(int k);
            logic [bmp_pkg::WORD_W-1:0] w;
            w = (k < 4) ? low_word : high_word;
            return int'($signed(w[(k % 4) * bmp_pkg::MV_W +: bmp_pkg::MV_W]));
        endfunction

        function logic [bmp_pkg::PCT_W-1:0] expected_percent(
            logic signed [bmp_pkg::MV_W-1:0] mv);
            int n;
            int v;
            int lo;
            int hi;
            int step;
            n = int'(points_used);
            if (n < 1) n = 1;
            if (n > bmp_pkg::MAX_POINTS_DEF) n = bmp_pkg::MAX_POINTS_DEF;
            v = int'(mv);
            if (v < breakpoint(0)) return bmp_pkg::PCT_ZERO;
            if (v >= breakpoint(n - 1)) return bmp_pkg::PCT_FULL;
            for (int i = 1; i < n; i++) begin
                hi = breakpoint(i);
                if (v < hi) begin
                    lo = breakpoint(i - 1);
                    step = int'(bmp_pkg::PCT_FULL) / (n - 1);
                    if (hi - lo <= 0) return bmp_pkg::PCT_FULL;
                    return bmp_pkg::PCT_W'((i - 1) * step + ((v - lo) * step) / (hi - lo));
                end
            end
            return bmp_pkg::PCT_FULL;
        endfunction

        function void note_request(logic signed [bmp_pkg::MV_W-1:0] mv);
            pending_percent.push_back(expected_percent(mv));
        endfunction

        function void check_result(logic [bmp_pkg::PCT_W-1:0] got);
            logic [bmp_pkg::PCT_W-1:0] want;
            if (pending_percent.size() == 0) begin
                bad_count++;
                if (bad_count <= REPORT_MAX)
                    $display("%0t: unexpected result, charge_percent=%0d", $realtime, got);
            end else begin
                want = pending_percent.pop_front();
                if (got !== want) begin
                    bad_count++;
                    if (bad_count <= REPORT_MAX)
                        $display("%0t: charge_percent mismatch, expected %0d, actual %0d",
                                 $realtime, want, got);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [bmp_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [bmp_pkg::WORD_W-1:0]      i_cfg_data;
    logic                            i_push;
    logic                            o_full;
    logic signed [bmp_pkg::MV_W-1:0] i_battery_millivolts;
    logic                            o_empty;
    logic                            i_pop;
    logic [bmp_pkg::PCT_W-1:0]       o_charge_percent;

    battery_mv_to_percent_interp uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_push               (i_push),
        .o_full               (o_full),
        .i_battery_millivolts (i_battery_millivolts),
        .o_empty              (o_empty),
        .i_pop                (i_pop),
        .o_charge_percent     (o_charge_percent)
    );

    charge_ledger                    ledger;

    // Table the stimulus is built around; mirrors what was last loaded.
    logic signed [bmp_pkg::MV_W-1:0] table_mv[bmp_pkg::SLOTS];
    int                              active_points = 2;
    // One in stall_odds pop cycles or requests starts an idle burst on that side; 0 = none.
    int                              stall_odds = 0;
    int                              cycle_count = 0;

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Watchdog: give up if the run hangs anywhere.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_battery_mv_to_percent_interp: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks: change inputs on the falling edge, sample on rising.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [bmp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bmp_pkg::WORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        ledger.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Pack table_mv into both words and load them with a point count.
    // Upper bits of the count word carry noise; only the low nibble counts.
    task automatic load_table(input logic [bmp_pkg::CNT_W-1:0] count);
        logic [bmp_pkg::WORD_W-1:0] lw;
        logic [bmp_pkg::WORD_W-1:0] hw;
        logic [bmp_pkg::WORD_W-1:0] cw;
        for (int k = 0; k < 4; k++) begin
            lw[k * bmp_pkg::MV_W +: bmp_pkg::MV_W] = table_mv[k];
            hw[k * bmp_pkg::MV_W +: bmp_pkg::MV_W] = table_mv[k + 4];
        end
        cw = {$urandom, $urandom};
        cw[bmp_pkg::CNT_W-1:0] = count;
        write_reg(bmp_pkg::CFG_PTS_LO, lw);
        write_reg(bmp_pkg::CFG_PTS_HI, hw);
        write_reg(bmp_pkg::CFG_PTS_USE, cw);
        active_points = (count < 1) ? 1 :
                        (count > bmp_pkg::MAX_POINTS_DEF) ? bmp_pkg::MAX_POINTS_DEF : count;
    endtask

    // Hold the request until the block takes it, then log it for checking.
    task automatic push_request(input logic signed [bmp_pkg::MV_W-1:0] mv);
        @(negedge i_clk);
        i_push               <= 1'b1;
        i_battery_millivolts <= mv;
        do @(posedge i_clk); while (o_full);
        ledger.note_request(mv);
    endtask

    task automatic sender_gap();
        int n;
        if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
            n = $urandom_range(1, MAX_BURST);
            @(negedge i_clk);
            i_push <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until every predicted result has been popped,
    // then let the pipeline settle before touching the registers.
    task automatic drain();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (ledger.pending_percent.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Build an ascending table: random base, steps of 1..max_step mV.
    task automatic make_ascending(input int max_step);
        int v;
        v = -32768 + int'($urandom_range(0, 65535 - (bmp_pkg::SLOTS - 1) * max_step));
        table_mv[0] = v[bmp_pkg::MV_W-1:0];
        for (int k = 1; k < bmp_pkg::SLOTS; k++) begin
            v += int'($urandom_range(1, max_step));
            table_mv[k] = v[bmp_pkg::MV_W-1:0];
        end
    endtask

    // Aim mostly at breakpoints and segment interiors; some raw noise.
    function automatic logic signed [bmp_pkg::MV_W-1:0] pick_mv();
        int r;
        int k;
        int v;
        int lo;
        int hi;
        logic [bmp_pkg::MV_W-1:0] raw;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            raw = bmp_pkg::MV_W'($urandom);
            return raw;
        end
        if (r < 4 || active_points < 2) begin
            k = $urandom_range(0, active_points - 1);
            v = int'(table_mv[k]) + int'($urandom_range(0, 6)) - 3;
        end else begin
            k  = $urandom_range(0, active_points - 2);
            lo = int'(table_mv[k]);
            hi = int'(table_mv[k + 1]);
            if (hi > lo)
                v = lo + int'($urandom_range(0, hi - lo));
            else
                v = lo + int'($urandom_range(0, 6)) - 3;
        end
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v[bmp_pkg::MV_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Result side: pop with random stall bursts, check every accepted pop.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        stall = 0;
        i_pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall == 0 && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
                stall = $urandom_range(1, MAX_BURST);
            if (stall > 0) begin
                i_pop <= 1'b0;
                stall--;
            end else begin
                i_pop <= 1'b1;
            end
            @(posedge i_clk);
            if (i_pop && !o_empty)
                ledger.check_result(o_charge_percent);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int count_pick;
        logic [bmp_pkg::CNT_W-1:0] count;
        logic [bmp_pkg::WORD_W-1:0] lw;
        logic [bmp_pkg::WORD_W-1:0] hw;

        ledger = new;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        i_push               = 1'b0;
        i_battery_millivolts = '0;
        for (int k = 0; k < bmp_pkg::SLOTS; k++) table_mv[k] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset table is all zero with two points in use.
        stall_odds = 6;
        push_request(-16'sd1);
        push_request(16'sd0);
        push_request(16'sd1);
        push_request(-16'sd32768);
        drain();

        // Typical cell curve, all eight points: field extremes, edges of
        // the table, exact breakpoints and a mid-segment value.
        table_mv = '{16'sd3000, 16'sd3300, 16'sd3500, 16'sd3700,
                     16'sd3800, 16'sd3900, 16'sd4000, 16'sd4200};
        load_table(4'd8);
        push_request(-16'sd32768);
        push_request(16'sd32767);
        push_request(16'sd2999);
        push_request(16'sd3000);
        push_request(16'sd3299);
        push_request(16'sd3300);
        push_request(16'sd3650);
        push_request(16'sd4199);
        push_request(16'sd4200);
        drain();

        // Zero count reads as one point; one point has no step at all.
        load_table(4'd0);
        push_request(16'sd2999);
        drain();
        load_table(4'd1);
        push_request(16'sd3000);
        drain();

        // Counts above the table size saturate at eight points.
        load_table(4'd9);
        push_request(16'sd4100);
        drain();
        load_table(4'd15);
        push_request(16'sd4199);
        drain();

        // Table out of order: segment is still bounded by the first point
        // above the voltage.
        table_mv = '{16'sd100, 16'sd500, 16'sd200, 16'sd900,
                     16'sd50, 16'sd60, 16'sd70, 16'sd80};
        load_table(4'd4);
        push_request(16'sd300);
        push_request(16'sd600);
        push_request(16'sd50);
        push_request(16'sd900);
        drain();

        // Widest possible segment, then a write to the unmapped index,
        // which must leave the table alone.
        table_mv[0] = -16'sd32768;
        table_mv[1] = 16'sd32767;
        load_table(4'd2);
        write_reg(CFG_UNMAPPED, '1);
        push_request(16'sd32766);
        push_request(-16'sd32768);
        push_request(16'sd32767);

        // Random phases: fresh table and count each time, idling varied
        // per phase and switched off in the last one.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph % 4)
                0: stall_odds = 0;
                1: stall_odds = 3;
                2: stall_odds = 8;
                default: stall_odds = 24;
            endcase
            if (ph == RANDOM_PHASES - 1) stall_odds = 0;

            mode = $urandom_range(0, 4);
            case (mode)
                0: begin
                    // Raw words: arbitrary, usually unordered table.
                    lw = {$urandom, $urandom};
                    hw = {$urandom, $urandom};
                    for (int k = 0; k < 4; k++) begin
                        table_mv[k]     = lw[k * bmp_pkg::MV_W +: bmp_pkg::MV_W];
                        table_mv[k + 4] = hw[k * bmp_pkg::MV_W +: bmp_pkg::MV_W];
                    end
                end
                1: make_ascending(3);
                2: make_ascending(250);
                3: make_ascending(2000);
                default: make_ascending(9000);
            endcase

            count_pick = $urandom_range(0, 19);
            if (count_pick == 0)
                count = 4'd0;
            else if (count_pick == 1)
                count = 4'd1;
            else if (count_pick == 2)
                count = bmp_pkg::CNT_W'($urandom_range(9, 15));
            else
                count = bmp_pkg::CNT_W'($urandom_range(2, 8));
            load_table(count);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNMAPPED, {$urandom, $urandom});

            for (int it = 0; it < PHASE_ITEMS; it++) begin
                // Once, hold off mid-phase until the pipeline is empty.
                if (ph == 3 && it == PHASE_ITEMS / 2)
                    drain();
                push_request(pick_mv());
                sender_gap();
            end
        end

        drain();
        if (ledger.bad_count == 0 && ledger.pending_percent.size() == 0)
            $display("tb_battery_mv_to_percent_interp: done, clean");
        else
            $display("tb_battery_mv_to_percent_interp: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
src/bmp_pkg.sv
src/bmp_queue.sv
src/bmp_front.sv
src/bmp_back.sv
src/battery_mv_to_percent_interp.sv
verif/tb_battery_mv_to_percent_interp.sv
